// ===== design/macs_pkg.sv =====
// ----------------------------------------------------------------------------
// macs_pkg: shared types, constants and helpers
// Fixed-point formats, the arctangent table of the CORDIC units and the
// rounded Q2.30 multiply used throughout the mount axis angle solver.
// ----------------------------------------------------------------------------
package macs_pkg;

  localparam int TAB_LEN = 40;
  localparam int FXW     = 34;   // Q2.30 values with headroom for sums
  localparam int CW      = 36;   // CORDIC datapath width, covers the gain growth

  typedef logic signed [FXW-1:0] fx_t;
  typedef logic signed [CW-1:0]  cw_t;

  localparam fx_t ONE_Q30  = 34'sd1073741824;
  localparam cw_t GAIN_INV = 36'sd652032874;

  localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
    32'd20,        32'd10,        32'd5,         32'd3,        32'd1,
    32'd1,         32'd0,         32'd0,         32'd0,        32'd0,
    32'd0,         32'd0,         32'd0,         32'd0,        32'd0
  };

  typedef struct packed {
    fx_t ax;
    fx_t ay;
    fx_t az;
    fx_t bx;
    fx_t by;
    fx_t bz;
  } vec_t;

  // Clamp a raw component to the closed unit interval.
  function automatic fx_t sat_unit(input logic [31:0] v);
    logic signed [31:0] s;
    begin
      s = v;
      if (s > 32'sd1073741824) begin
        return ONE_Q30;
      end else if (s < -32'sd1073741824) begin
        return -ONE_Q30;
      end else begin
        return fx_t'(s);
      end
    end
  endfunction

  // Q2.30 product, rounded by adding one half and flooring.
  function automatic fx_t qmul(input fx_t a, input fx_t b);
    logic signed [2*FXW-1:0] p;
    begin
      p = a * b;
      p = p + (2*FXW)'(64'sd536870912);
      return p[FXW+29:30];
    end
  endfunction

endpackage

// ===== design/macs_cordic.sv =====
// ----------------------------------------------------------------------------
// macs_cordic: pipelined CORDIC, one iteration per stage
// Rotation mode gives cos and sin of a binary angle; vectoring mode gives
// the binary angle of a vector.
// ----------------------------------------------------------------------------
module macs_cordic #(
  parameter int STEPS  = 30,
  parameter bit VECTOR = 1'b0
) (
  input  logic          clk,
  input  logic          en,
  input  macs_pkg::cw_t x_in,
  input  macs_pkg::cw_t y_in,
  input  logic [31:0]   z_in,
  output macs_pkg::cw_t x_out,
  output macs_pkg::cw_t y_out,
  output logic [31:0]   z_out
);
  import macs_pkg::*;

  localparam int N = (STEPS > TAB_LEN) ? TAB_LEN : STEPS;

  cw_t                xs [N+1];
  cw_t                ys [N+1];
  logic signed [33:0] zs [N+1];
  logic               fl [N+1];

  // Entry stage: quadrant fold and, in vectoring mode, the zero-vector mark.
  generate
    if (VECTOR) begin : g_vec_pre
      always_ff @(posedge clk) begin
        if (en) begin
          fl[0] <= (x_in == '0) && (y_in == '0);
          if (x_in < 0) begin
            xs[0] <= -x_in;
            ys[0] <= -y_in;
            zs[0] <= 34'sh0_8000_0000;
          end else begin
            xs[0] <= x_in;
            ys[0] <= y_in;
            zs[0] <= '0;
          end
        end
      end
    end else begin : g_rot_pre
      logic [31:0] shifted;
      logic [31:0] folded;
      assign shifted = z_in + 32'h4000_0000;
      assign folded  = shifted[31] ? (z_in + 32'h8000_0000) : z_in;
      always_ff @(posedge clk) begin
        if (en) begin
          fl[0] <= shifted[31];
          xs[0] <= GAIN_INV;
          ys[0] <= '0;
          zs[0] <= {{2{folded[31]}}, folded};
        end
      end
    end
  endgenerate

  generate
    for (genvar i = 0; i < N; i++) begin : g_step
      cw_t                dx;
      cw_t                dy;
      logic signed [33:0] tab;
      logic               up;
      assign dx  = xs[i] >>> i;
      assign dy  = ys[i] >>> i;
      assign tab = {2'b00, ATAN_TAB[i]};
      assign up  = VECTOR ? (ys[i] > 0) : (zs[i] >= 0);
      always_ff @(posedge clk) begin
        if (en) begin
          fl[i+1] <= fl[i];
          if (VECTOR) begin
            xs[i+1] <= up ? (xs[i] + dy) : (xs[i] - dy);
            ys[i+1] <= up ? (ys[i] - dx) : (ys[i] + dx);
            zs[i+1] <= up ? (zs[i] + tab) : (zs[i] - tab);
          end else begin
            xs[i+1] <= up ? (xs[i] - dy) : (xs[i] + dy);
            ys[i+1] <= up ? (ys[i] + dx) : (ys[i] - dx);
            zs[i+1] <= up ? (zs[i] - tab) : (zs[i] + tab);
          end
        end
      end
    end
  endgenerate

  // Exit stage: undo the half-turn fold, or force a zero angle for a null vector.
  always_ff @(posedge clk) begin
    if (en) begin
      if (VECTOR) begin
        x_out <= xs[N];
        y_out <= ys[N];
        z_out <= fl[N] ? 32'd0 : zs[N][31:0];
      end else begin
        x_out <= fl[N] ? -xs[N] : xs[N];
        y_out <= fl[N] ? -ys[N] : ys[N];
        z_out <= zs[N][31:0];
      end
    end
  end

endmodule

// ===== design/macs_isqrt.sv =====
// ----------------------------------------------------------------------------
// macs_isqrt: pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module macs_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n_in,
  output logic [31:0] root_out
);
  import macs_pkg::*;

  localparam int SL = 32;

  logic [35:0] rem_q  [SL];
  logic [31:0] root_q [SL];
  logic [63:0] n_q    [SL];

  generate
    for (genvar k = 0; k < SL; k++) begin : g_bit
      logic [35:0] rem_p;
      logic [31:0] root_p;
      logic [63:0] n_p;
      logic [35:0] rem_c;
      logic [35:0] trial;
      if (k == 0) begin : g_first
        assign rem_p  = '0;
        assign root_p = '0;
        assign n_p    = n_in;
      end else begin : g_next
        assign rem_p  = rem_q[k-1];
        assign root_p = root_q[k-1];
        assign n_p    = n_q[k-1];
      end
      assign rem_c = {rem_p[33:0], n_p[63:62]};
      assign trial = {2'b00, root_p, 2'b01};
      always_ff @(posedge clk) begin
        if (en) begin
          n_q[k] <= {n_p[61:0], 2'b00};
          if (rem_c >= trial) begin
            rem_q[k]  <= rem_c - trial;
            root_q[k] <= {root_p[30:0], 1'b1};
          end else begin
            rem_q[k]  <= rem_c;
            root_q[k] <= {root_p[30:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign root_out = root_q[SL-1];

endmodule

// ===== design/mount_axis_angle_solver_unit.sv =====
// ----------------------------------------------------------------------------
// mount_axis_angle_solver_unit: two-solution mount axis angle solver
// Takes an aim and a boresight unit vector and returns pitch and roll for
// both roots of the mount equation, with the nonperpendicularity correction.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries aim_* and bore_* in Q2.30.
//   Output channel (out_valid / out_stall) carries roll and pitch of the
//   positive and negative root plus no_solution; angles are binary angles.
//   nonperp_angle is written through cfg_we / cfg_wdata; the user must do so
//   only while the unit idles, which the unit does not enforce. A new item
//   can enter on every clock while out_stall does not hold a waiting item,
//   so the sustained rate is one item per cycle; the single pipeline runs
//   through four CORDIC passes in series and the 32-stage square root.
//   While out_stall holds a waiting item the whole pipeline freezes and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Synchronous reset empties the pipeline and clears nonperp_angle to zero.
//   A negative radicand gives no_solution = 1 with all four angles zero.
// ----------------------------------------------------------------------------
module mount_axis_angle_solver_unit #(
  parameter int CORDIC_STEPS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] aim_x,
  input  logic signed [31:0] aim_y,
  input  logic signed [31:0] aim_z,
  input  logic signed [31:0] bore_x,
  input  logic signed [31:0] bore_y,
  input  logic signed [31:0] bore_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] roll_first,
  output logic signed [31:0] pitch_first,
  output logic signed [31:0] roll_second,
  output logic signed [31:0] pitch_second,
  output logic               no_solution
);
  import macs_pkg::*;

  localparam int N  = (CORDIC_STEPS > TAB_LEN) ? TAB_LEN : CORDIC_STEPS;
  localparam int CL = N + 2;
  localparam int SL = 32;
  localparam int L  = 1 + CL + 4 + SL + CL + 1 + CL + 6 + CL + 1;

  typedef struct packed {
    vec_t        v;
    fx_t         cn;
    fx_t         sn;
    logic [31:0] bang;
    fx_t         num;
    logic        neg;
  } sq_bundle_t;

  typedef struct packed {
    vec_t        v;
    fx_t         cn;
    fx_t         sn;
    logic [31:0] p1;
    logic [31:0] p2;
    logic        neg;
  } ang_t;

  logic        en;
  logic [31:0] nonperp_angle;
  logic [L-1:0] vld;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      nonperp_angle <= '0;
    end else if (cfg_we) begin
      nonperp_angle <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  // Entry: clamp components and capture the angle with the item.
  vec_t        s0_vec;
  logic [31:0] s0_np;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_vec.ax <= sat_unit(aim_x);
      s0_vec.ay <= sat_unit(aim_y);
      s0_vec.az <= sat_unit(aim_z);
      s0_vec.bx <= sat_unit(bore_x);
      s0_vec.by <= sat_unit(bore_y);
      s0_vec.bz <= sat_unit(bore_z);
      s0_np     <= nonperp_angle;
    end
  end

  // Phase A: sin/cos of the nonperpendicularity and the boresight azimuth.
  cw_t         np_c;
  cw_t         np_s;
  logic [31:0] bang_a;
  vec_t        d_a [CL];

  macs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_np_rot (
    .clk(clk), .en(en), .x_in('0), .y_in('0), .z_in(s0_np),
    .x_out(np_c), .y_out(np_s), .z_out()
  );

  macs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_bore_vec (
    .clk(clk), .en(en), .x_in(cw_t'(s0_vec.bx)), .y_in(cw_t'(s0_vec.bz)),
    .z_in('0), .x_out(), .y_out(), .z_out(bang_a)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d_a[0] <= s0_vec;
      for (int k = 1; k < CL; k++) begin
        d_a[k] <= d_a[k-1];
      end
    end
  end

  // Phase B: radicand, four stages.
  vec_t        b1_v, b2_v, b3_v, b4_v;
  fx_t         b1_cn, b2_cn, b3_cn, b4_cn;
  fx_t         b1_sn, b2_sn, b3_sn, b4_sn;
  logic [31:0] b1_bang, b2_bang, b3_bang, b4_bang;
  fx_t         b1_ax2, b1_ay2, b1_azs, b1_ss, b1_sby;
  fx_t         b2_sq, b2_ss, b2_q, b2_num;
  fx_t         b3_sq, b3_ss, b3_bq, b3_num;
  fx_t         b4_num;
  fx_t         b3_r;
  logic        b4_neg;
  logic [63:0] b4_n;

  always_ff @(posedge clk) begin
    if (en) begin
      b1_v    <= d_a[CL-1];
      b1_cn   <= np_c[FXW-1:0];
      b1_sn   <= np_s[FXW-1:0];
      b1_bang <= bang_a;
      b1_ax2  <= qmul(d_a[CL-1].ax, d_a[CL-1].ax);
      b1_ay2  <= qmul(d_a[CL-1].ay, d_a[CL-1].ay);
      b1_azs  <= qmul(d_a[CL-1].az, np_s[FXW-1:0]);
      b1_ss   <= qmul(np_s[FXW-1:0], np_s[FXW-1:0]);
      b1_sby  <= qmul(np_s[FXW-1:0], d_a[CL-1].by);

      b2_v    <= b1_v;
      b2_cn   <= b1_cn;
      b2_sn   <= b1_sn;
      b2_bang <= b1_bang;
      b2_sq   <= b1_ax2 + b1_ay2;
      b2_ss   <= b1_ss;
      b2_q    <= (b1_azs <<< 1) + b1_v.by;
      b2_num  <= b1_v.az + b1_sby;

      b3_v    <= b2_v;
      b3_cn   <= b2_cn;
      b3_sn   <= b2_sn;
      b3_bang <= b2_bang;
      b3_sq   <= b2_sq;
      b3_ss   <= b2_ss;
      b3_bq   <= qmul(b2_v.by, b2_q);
      b3_num  <= b2_num;

      b4_v    <= b3_v;
      b4_cn   <= b3_cn;
      b4_sn   <= b3_sn;
      b4_bang <= b3_bang;
      b4_num  <= b3_num;
      b4_neg  <= b3_r < 0;
      b4_n    <= (b3_r < 0) ? 64'd0 : {b3_r, 30'd0};
    end
  end

  assign b3_r = b3_sq - b3_bq - b3_ss;

  // Square root of the radicand, carried alongside its operands.
  logic [31:0] root;
  sq_bundle_t  d_s [SL];
  sq_bundle_t  s_in;

  assign s_in = '{v: b4_v, cn: b4_cn, sn: b4_sn, bang: b4_bang, num: b4_num,
                  neg: b4_neg};

  macs_isqrt u_isqrt (.clk(clk), .en(en), .n_in(b4_n), .root_out(root));

  always_ff @(posedge clk) begin
    if (en) begin
      d_s[0] <= s_in;
      for (int k = 1; k < SL; k++) begin
        d_s[k] <= d_s[k-1];
      end
    end
  end

  // Phase D: elevation angle for both root signs.
  cw_t         root_w;
  logic [31:0] zd [2];
  sq_bundle_t  d_d [CL];

  assign root_w = cw_t'({4'b0000, root});

  macs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_pos_vec (
    .clk(clk), .en(en), .x_in(root_w), .y_in(cw_t'(d_s[SL-1].num)),
    .z_in('0), .x_out(), .y_out(), .z_out(zd[0])
  );

  macs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_neg_vec (
    .clk(clk), .en(en), .x_in(-root_w), .y_in(cw_t'(d_s[SL-1].num)),
    .z_in('0), .x_out(), .y_out(), .z_out(zd[1])
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d_d[0] <= d_s[SL-1];
      for (int k = 1; k < CL; k++) begin
        d_d[k] <= d_d[k-1];
      end
    end
  end

  // Pitch: subtract the boresight azimuth, wrapping modulo a full turn.
  ang_t p_b;

  always_ff @(posedge clk) begin
    if (en) begin
      p_b.v   <= d_d[CL-1].v;
      p_b.cn  <= d_d[CL-1].cn;
      p_b.sn  <= d_d[CL-1].sn;
      p_b.p1  <= zd[0] - d_d[CL-1].bang;
      p_b.p2  <= zd[1] - d_d[CL-1].bang;
      p_b.neg <= d_d[CL-1].neg;
    end
  end

  // Phase E: sin/cos of each pitch.
  cw_t  cp [2];
  cw_t  sp [2];
  ang_t d_e [CL];

  macs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_p1_rot (
    .clk(clk), .en(en), .x_in('0), .y_in('0), .z_in(p_b.p1),
    .x_out(cp[0]), .y_out(sp[0]), .z_out()
  );

  macs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_p2_rot (
    .clk(clk), .en(en), .x_in('0), .y_in('0), .z_in(p_b.p2),
    .x_out(cp[1]), .y_out(sp[1]), .z_out()
  );

  always_ff @(posedge clk) begin
    if (en) begin
      d_e[0] <= p_b;
      for (int k = 1; k < CL; k++) begin
        d_e[k] <= d_e[k-1];
      end
    end
  end

  // Phase F: rotate the boresight and form the roll vector, six stages.
  ang_t f1, f2, f3, f4, f5, f6;
  fx_t  f1_cb0 [2], f1_sb2 [2], f1_cb2 [2], f1_sb0 [2];
  fx_t  f2_u0 [2], f2_u2 [2];
  fx_t  f3_u0 [2], f3_t1 [2], f3_t2 [2];
  fx_t  f4_v0 [2], f4_v1 [2];
  fx_t  f5_m1 [2], f5_m2 [2], f5_m3 [2], f5_m4 [2];
  fx_t  f6_y [2], f6_x [2];

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= d_e[CL-1];
      f2 <= f1;
      f3 <= f2;
      f4 <= f3;
      f5 <= f4;
      f6 <= f5;
      for (int j = 0; j < 2; j++) begin
        f1_cb0[j] <= qmul(cp[j][FXW-1:0], d_e[CL-1].v.bx);
        f1_sb2[j] <= qmul(sp[j][FXW-1:0], d_e[CL-1].v.bz);
        f1_cb2[j] <= qmul(cp[j][FXW-1:0], d_e[CL-1].v.bz);
        f1_sb0[j] <= qmul(sp[j][FXW-1:0], d_e[CL-1].v.bx);

        f2_u0[j] <= f1_cb0[j] + f1_sb2[j];
        f2_u2[j] <= f1_cb2[j] - f1_sb0[j];

        f3_u0[j] <= f2_u0[j];
        f3_t1[j] <= qmul(f2.cn, f2.v.by);
        f3_t2[j] <= qmul(f2.sn, f2_u2[j]);

        f4_v0[j] <= f3_u0[j];
        f4_v1[j] <= f3_t1[j] - f3_t2[j];

        f5_m1[j] <= qmul(f4.v.ay, f4_v0[j]);
        f5_m2[j] <= qmul(f4.v.ax, f4_v1[j]);
        f5_m3[j] <= qmul(f4.v.ax, f4_v0[j]);
        f5_m4[j] <= qmul(f4.v.ay, f4_v1[j]);

        f6_y[j] <= f5_m1[j] - f5_m2[j];
        f6_x[j] <= f5_m3[j] + f5_m4[j];
      end
    end
  end

  // Phase G: roll angle of each solution.
  logic [31:0] zg [2];
  ang_t        d_g [CL];

  generate
    for (genvar j = 0; j < 2; j++) begin : g_roll
      macs_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_roll_vec (
        .clk(clk), .en(en), .x_in(cw_t'(f6_x[j])), .y_in(cw_t'(f6_y[j])),
        .z_in('0), .x_out(), .y_out(), .z_out(zg[j])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      d_g[0] <= f6;
      for (int k = 1; k < CL; k++) begin
        d_g[k] <= d_g[k-1];
      end
    end
  end

  // Output register; a missing solution forces every angle to zero.
  always_ff @(posedge clk) begin
    if (en) begin
      no_solution  <= d_g[CL-1].neg;
      roll_first   <= d_g[CL-1].neg ? 32'sd0 : zg[0];
      pitch_first  <= d_g[CL-1].neg ? 32'sd0 : d_g[CL-1].p1;
      roll_second  <= d_g[CL-1].neg ? 32'sd0 : zg[1];
      pitch_second <= d_g[CL-1].neg ? 32'sd0 : d_g[CL-1].p2;
    end
  end

endmodule

// ===== design/macs_checker.sv =====
// ----------------------------------------------------------------------------
// macs_checker: port-level checks for the mount axis angle solver
// Watches the channels of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module macs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] roll_first,
  input logic signed [31:0] pitch_first,
  input logic signed [31:0] roll_second,
  input logic signed [31:0] pitch_second,
  input logic               no_solution
);

  // A held item keeps its place and its value while the receiver stalls.
  a_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(roll_first) &&
      $stable(pitch_first) && $stable(roll_second) && $stable(pitch_second))
    else $error("output item changed while stalled");

  // The input side stalls only when a finished item is held at the output.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  // A missing solution carries zero angles.
  a_zero_angles : assert property (@(posedge clk) disable iff (rst)
    out_valid && no_solution |-> roll_first == 0 && pitch_first == 0 &&
      roll_second == 0 && pitch_second == 0)
    else $error("no_solution item with nonzero angles");

  // Reset empties the pipeline.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output item after reset");

endmodule

bind mount_axis_angle_solver_unit macs_checker u_macs_checker (
  .clk(clk),
  .rst(rst),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .roll_first(roll_first),
  .pitch_first(pitch_first),
  .roll_second(roll_second),
  .pitch_second(pitch_second),
  .no_solution(no_solution)
);

// ===== sim/mount_axis_angle_solver_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mount_axis_angle_solver_unit_tb: self-checking bench for the angle solver
// A queue-fed driver sends aim and boresight vectors while the monitor checks
// every result against a bit-exact CORDIC predictor, over several settings
// of the nonperpendicularity angle, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module mount_axis_angle_solver_unit_tb;
  import macs_pkg::*;

  localparam int STEPS     = 30;
  localparam int LATENCY   = 4 * (STEPS + 2) + 45;
  localparam int WATCH_MAX = 20 * LATENCY + 2000;

  typedef struct {
    logic [31:0] ax, ay, az, bx, by, bz;
  } vec_item_t;

  typedef struct {
    logic [31:0] roll1, pitch1, roll2, pitch2;
    logic        nosol;
  } solution_t;

  logic clk, rst;
  logic cfg_we;
  logic [31:0] cfg_wdata;
  logic in_valid, in_stall;
  logic signed [31:0] aim_x, aim_y, aim_z, bore_x, bore_y, bore_z;
  logic out_valid, out_stall;
  logic signed [31:0] roll_first, pitch_first, roll_second, pitch_second;
  logic no_solution;

  vec_item_t pending_vecs[$];
  solution_t expected_solutions[$];
  logic [31:0] np_model;
  bit quiet;
  bit hold_sender;
  int mismatches, accepted_in, accepted_out, nosol_seen, idle_cycles;
  int settings_run;

  mount_axis_angle_solver_unit #(.CORDIC_STEPS(STEPS)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .aim_x(aim_x), .aim_y(aim_y), .aim_z(aim_z),
    .bore_x(bore_x), .bore_y(bore_y), .bore_z(bore_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .roll_first(roll_first), .pitch_first(pitch_first),
    .roll_second(roll_second), .pitch_second(pitch_second),
    .no_solution(no_solution)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint clamp_unit(logic [31:0] v);
    longint x;
    begin
      x = longint'($signed(v));
      if (x > 64'sd1073741824) return 64'sd1073741824;
      if (x < -64'sd1073741824) return -64'sd1073741824;
      return x;
    end
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic longint sqrt_floor(longint unsigned n);
    longint unsigned res, b;
    begin
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    end
  endfunction

  function automatic logic [31:0] vector_angle(longint y, longint x);
    logic [31:0] z;
    longint dx, dy;
    begin
      z = 32'd0;
      if (x == 0 && y == 0) return 32'd0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = 32'h8000_0000;
      end
      for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (y > 0) begin
          x = x + dy; y = y - dx; z = z + ATAN_TAB[i];
        end else begin
          x = x - dy; y = y + dx; z = z - ATAN_TAB[i];
        end
      end
      return z;
    end
  endfunction

  function automatic void rotate_sincos(input logic [31:0] ang, output longint c,
                                        output longint s);
    logic [31:0] a, t;
    bit neg;
    longint x, y, z, dx, dy;
    begin
      a = ang;
      neg = 1'b0;
      x = 64'sd652032874;
      y = 0;
      t = a + 32'h4000_0000;
      // Fold the left half plane onto the right one and negate at the end.
      if (t[31]) begin
        a = a + 32'h8000_0000;
        neg = 1'b1;
      end
      z = longint'($signed(a));
      for (int i = 0; i < STEPS && i < TAB_LEN; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (z >= 0) begin
          x = x - dy; y = y + dx; z = z - longint'(ATAN_TAB[i]);
        end else begin
          x = x + dy; y = y - dx; z = z + longint'(ATAN_TAB[i]);
        end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    end
  endfunction

  function automatic logic [31:0] roll_for_pitch(longint ax, longint ay, longint bx,
      longint by, longint bz, logic [31:0] pitch, longint cn, longint sn);
    longint cp, sp, u0, u2, v1;
    begin
      rotate_sincos(pitch, cp, sp);
      u0 = mul_q30(cp, bx) + mul_q30(sp, bz);
      u2 = mul_q30(cp, bz) - mul_q30(sp, bx);
      v1 = mul_q30(cn, by) - mul_q30(sn, u2);
      return vector_angle(mul_q30(ay, u0) - mul_q30(ax, v1),
                          mul_q30(ax, u0) + mul_q30(ay, v1));
    end
  endfunction

  function automatic solution_t solve_mount(vec_item_t it, logic [31:0] np);
    solution_t sol;
    longint ax, ay, az, bx, by, bz, cn, sn, rad, num, root;
    logic [31:0] bang;
    begin
      ax = clamp_unit(it.ax); ay = clamp_unit(it.ay); az = clamp_unit(it.az);
      bx = clamp_unit(it.bx); by = clamp_unit(it.by); bz = clamp_unit(it.bz);
      rotate_sincos(np, cn, sn);
      rad = mul_q30(ax, ax) + mul_q30(ay, ay)
            - mul_q30(by, 2 * mul_q30(az, sn) + by) - mul_q30(sn, sn);
      sol = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
      if (rad < 0) return sol;
      root = sqrt_floor(longint'(rad) << 30);
      num = az + mul_q30(sn, by);
      bang = vector_angle(bz, bx);
      sol.pitch1 = vector_angle(num, root) - bang;
      sol.pitch2 = vector_angle(num, -root) - bang;
      sol.roll1 = roll_for_pitch(ax, ay, bx, by, bz, sol.pitch1, cn, sn);
      sol.roll2 = roll_for_pitch(ax, ay, bx, by, bz, sol.pitch2, cn, sn);
      sol.nosol = 1'b0;
      return sol;
    end
  endfunction

  // ------------------------------------------------------------------ driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      aim_x <= '0; aim_y <= '0; aim_z <= '0;
      bore_x <= '0; bore_y <= '0; bore_z <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_solutions.push_back(solve_mount(pending_vecs.pop_front(), np_model));
        accepted_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_vecs.size() > 0 && !hold_sender &&
            (quiet || $urandom_range(99) >= 13)) begin
          in_valid <= 1'b1;
          aim_x <= pending_vecs[0].ax; aim_y <= pending_vecs[0].ay;
          aim_z <= pending_vecs[0].az; bore_x <= pending_vecs[0].bx;
          bore_y <= pending_vecs[0].by; bore_z <= pending_vecs[0].bz;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk) begin
    solution_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 13);
      if (in_valid && !in_stall || out_valid && !out_stall || (pending_vecs.size() == 0 &&
          expected_solutions.size() == 0)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (out_valid && !out_stall) begin
        accepted_out++;
        if (expected_solutions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item at %0t", $realtime);
        end else begin
          want = expected_solutions.pop_front();
          if (no_solution) nosol_seen++;
          if (roll_first !== want.roll1 || pitch_first !== want.pitch1 ||
              roll_second !== want.roll2 || pitch_second !== want.pitch2 ||
              no_solution !== want.nosol) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: got r1=%h p1=%h r2=%h p2=%h ns=%b, want r1=%h p1=%h r2=%h p2=%h ns=%b",
                       roll_first, pitch_first, roll_second, pitch_second, no_solution,
                       want.roll1, want.pitch1, want.roll2, want.pitch2, want.nosol);
          end
        end
      end
      if (idle_cycles >= WATCH_MAX) begin
        $display("[mount_axis_angle_solver_unit] ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------- stimulus
  function automatic logic [31:0] to_q30(real v);
    return 32'($rtoi(v * 1073741824.0));
  endfunction

  function automatic real urand(real lo, real hi);
    return lo + (hi - lo) * ($urandom_range(1000000) / 1000000.0);
  endfunction

  task automatic add_vec(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                         logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
    vec_item_t it;
    it = '{ax, ay, az, bx, by, bz};
    pending_vecs.push_back(it);
  endtask

  task automatic add_random_vec();
    real th, zz, rr, bth, bph;
    int pick;
    begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        // Unit aim, boresight close to the x-z plane: mostly solvable geometry.
        th = urand(-3.14159, 3.14159);
        zz = urand(-1.0, 1.0);
        rr = $sqrt(1.0 - zz * zz);
        bth = urand(-0.3, 0.3);
        bph = urand(-3.14159, 3.14159);
        add_vec(to_q30(rr * $cos(th)), to_q30(rr * $sin(th)), to_q30(zz),
                to_q30($cos(bth) * $cos(bph)), to_q30($sin(bth)),
                to_q30($cos(bth) * $sin(bph)));
      end else if (pick < 90) begin
        add_vec($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        add_vec($urandom_range(2147483647) >> $urandom_range(31),
                -($urandom_range(1073741824)), $urandom_range(1073741824),
                $urandom, -($urandom_range(1073741824)), $urandom_range(1073741824));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_vecs.size() > 0 || expected_solutions.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_nonperp(logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    np_model = v;
    settings_run++;
    @(posedge clk);
  endtask

  localparam logic [31:0] P1 = 32'h4000_0000;
  localparam logic [31:0] M1 = 32'hC000_0000;

  initial begin
    logic [31:0] np_values[6];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    np_model = '0;
    quiet = 1'b0;
    hold_sender = 1'b0;
    mismatches = 0; accepted_in = 0; accepted_out = 0; nosol_seen = 0;
    idle_cycles = 0; settings_run = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items at the reset value of the angle.
    add_vec(P1, 0, 0, P1, 0, 0);          // half-turn pitch on the negative root
    add_vec(0, 0, P1, P1, 0, 0);          // zero radicand, zero root
    add_vec(0, 0, 0, P1, 0, 0);           // zero root and zero numerator
    add_vec(0, 0, P1, 0, P1, 0);          // negative radicand
    add_vec(0, 0, 0, 0, 0, 0);
    add_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_vec(M1, 0, 0, M1, 0, 0);
    add_vec(0, P1, 0, 0, 0, P1);
    add_vec(0, M1, M1, 0, 0, M1);
    add_vec(32'h4000_0001, 32'hBFFF_FFFF, 0, 32'hFFFF_FFFF, 1, 0);
    add_vec(to_q30(0.7071), to_q30(0.7071), 0, to_q30(0.7071), 0, to_q30(0.7071));
    add_vec(to_q30(-0.6), to_q30(0.0), to_q30(0.8), to_q30(0.8), to_q30(0.6), 0);
    wait_drained();

    np_values = '{32'h0100_0000, 32'hFF00_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  $urandom, 32'h0000_0000};
    foreach (np_values[p]) begin
      write_nonperp(np_values[p]);
      quiet = (p == 1);
      add_vec(0, 0, P1, P1, 0, 0);
      add_vec(P1, 0, 0, P1, P1, 0);
      for (int k = 0; k < 305; k++) begin
        add_random_vec();
        // Once, let traffic build up, then hold the sender until the
        // pipeline is empty mid-phase.
        if (p == 2 && k == 150) begin
          repeat (100) @(posedge clk);
          hold_sender = 1'b1;
          while (expected_solutions.size() > 0 || in_valid) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      wait_drained();
    end
    quiet = 1'b0;

    $display("Sent %0d vector items over %0d angle settings; %0d results checked,",
             accepted_in, settings_run + 1, accepted_out);
    $display("%0d of them without a solution.", nosol_seen);
    if (mismatches == 0) begin
      $display("[mount_axis_angle_solver_unit] OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[mount_axis_angle_solver_unit] ERROR");
    end
    $finish;
  end

endmodule
